@@ rtl/core/lav_pkg.sv @@
// shared constants for the look-at view matrix pipeline
`default_nettype none

package lav_pkg;

  // block scaling puts the largest magnitude in [2^29, 2^30)
  localparam int NORM_MSB = 29;
  localparam int NORM_W   = 30;
  // squares and their sum after scaling
  localparam int SQ_W     = 2 * NORM_W;
  localparam int SUM_W    = SQ_W + 2;
  // integer square root of the sum, one result bit per stage
  localparam int ROOT_W   = SUM_W / 2;
  localparam int REM_W    = ROOT_W + 4;
  // up vector magnitudes are cut below this many bits before the cross product
  localparam int UP_MAG_BITS = 32;

endpackage

`default_nettype wire

@@ rtl/core/lav_norm.sv @@
// pipelined vector normaliser: block scale, square root, per-component division
`default_nettype none

module lav_norm #(
  parameter int VW     = 33,
  parameter int FB     = 16,
  parameter int SIDE_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     vin,
  input  logic signed [VW-1:0]     vec [3],
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     vout,
  output logic signed [FB+1:0]     unit [3],
  output logic [SIDE_W-1:0]        side_out
);
  import lav_pkg::*;

  localparam int AW   = FB + 2;
  localparam int PB   = $clog2(VW);
  localparam int SHW  = $clog2(VW + 1);
  localparam int NW   = NORM_W + FB + 1;
  localparam int DRW  = ROOT_W;
  // stage numbers
  localparam int ST_N   = 6 + ROOT_W;
  localparam int ST_DIV = ST_N + 1;
  localparam int LAT    = ST_DIV + FB + 1;
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

  logic [LAT:1]        vld;
  logic [SIDE_W-1:0]   side_l [1:LAT];
  logic [2:0]          neg_l  [1:LAT];
  logic                zero_l [1:LAT];
  logic [NORM_W-1:0]   ms_l   [3:ST_N-1][3];

  logic [VW-1:0]       mag_c [3];
  logic [VW-1:0]       m1 [3];
  logic [VW-1:0]       orv1;
  logic [VW-1:0]       m2 [3];
  logic [PB-1:0]       p2;
  logic [PB-1:0]       p_c;
  logic [SQ_W-1:0]     sq4 [3];
  logic [SUM_W-1:0]    sum5;

  logic [REM_W-1:0]    sq_rem  [ROOT_W];
  logic [ROOT_W-1:0]   sq_root [ROOT_W];
  logic [SUM_W-1:0]    sq_n    [ROOT_W];

  logic [NW-1:0]       n_top [3];
  logic [ROOT_W-1:0]   len_top;

  logic [DRW-1:0]      dv_rem [FB+1][3];
  logic [FB:0]         dv_nl  [FB+1][3];
  logic [FB:0]         dv_q   [FB+1][3];
  logic [ROOT_W-1:0]   dv_len [FB+1];

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], vin};
    end
  end

  // magnitudes and signs of the request
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
    end
  end

  // side data, signs and zero flag travel with the request
  always_ff @(posedge clk) begin
    if (en) begin
      side_l[1] <= side_in;
      zero_l[1] <= (mag_c[0] | mag_c[1] | mag_c[2]) == '0;
      for (int i = 0; i < 3; i++) begin
        neg_l[1][i] <= vec[i][VW-1];
        m1[i]       <= mag_c[i];
      end
      orv1 <= mag_c[0] | mag_c[1] | mag_c[2];
      for (int k = 2; k <= LAT; k++) begin
        side_l[k] <= side_l[k-1];
        neg_l[k]  <= neg_l[k-1];
        zero_l[k] <= zero_l[k-1];
      end
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    p_c = '0;
    for (int j = 0; j < VW; j++) begin
      if (orv1[j]) p_c = PB'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2 <= p_c;
      for (int i = 0; i < 3; i++) m2[i] <= m1[i];
    end
  end

  // block scale: take the 30 bits below and including the leading one
  logic [VW+NORM_W-1:0] scl [3];
  logic [SHW-1:0]       sh_amt;
  always_comb begin
    sh_amt = SHW'(p2) + SHW'(1);
    for (int i = 0; i < 3; i++) begin
      scl[i] = {m2[i], {NORM_W{1'b0}}} >> sh_amt;
    end
  end

  // scaled magnitudes wait alongside the square root
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) ms_l[3][i] <= scl[i][NORM_W-1:0];
      for (int k = 4; k <= ST_N - 1; k++) begin
        for (int i = 0; i < 3; i++) ms_l[k][i] <= ms_l[k-1][i];
      end
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq4[i] <= ms_l[3][i] * ms_l[3][i];
      sum5 <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0]  rin;
    logic [ROOT_W-1:0] qin;
    logic [SUM_W-1:0]  nin;
    logic [REM_W-1:0]  rsh;
    logic [REM_W-1:0]  tst;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign nin = sum5;
    end else begin : g_next
      assign rin = sq_rem[k-1];
      assign qin = sq_root[k-1];
      assign nin = sq_n[k-1];
    end
    assign rsh = {rin[REM_W-3:0], nin[SUM_W-1:SUM_W-2]};
    assign tst = {{(REM_W-ROOT_W-2){1'b0}}, qin, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rsh >= tst) begin
          sq_rem[k]  <= rsh - tst;
          sq_root[k] <= {qin[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[k]  <= rsh;
          sq_root[k] <= {qin[ROOT_W-2:0], 1'b0};
        end
        sq_n[k] <= {nin[SUM_W-3:0], 2'b00};
      end
    end
  end

  // dividend with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      len_top <= sq_root[ROOT_W-1];
      for (int i = 0; i < 3; i++) begin
        n_top[i] <= NW'({ms_l[ST_N-1][i], {FB{1'b0}}}) + NW'(sq_root[ROOT_W-1] >> 1);
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j <= FB; j++) begin : g_div
    logic [DRW-1:0]    rin [3];
    logic [FB:0]       nlin [3];
    logic [FB:0]       qin [3];
    logic [ROOT_W-1:0] lin;
    logic [DRW:0]      t [3];
    if (j == 0) begin : g_first
      assign lin = len_top;
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign rin[i]  = DRW'(n_top[i] >> (FB + 1));
        assign nlin[i] = n_top[i][FB:0];
        assign qin[i]  = '0;
      end
    end else begin : g_next
      assign lin = dv_len[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign rin[i]  = dv_rem[j-1][i];
        assign nlin[i] = dv_nl[j-1][i];
        assign qin[i]  = dv_q[j-1][i];
      end
    end
    always_comb begin
      for (int i = 0; i < 3; i++) t[i] = {rin[i], nlin[i][FB]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_len[j] <= lin;
        for (int i = 0; i < 3; i++) begin
          if (t[i] >= (DRW+1)'(lin)) begin
            dv_rem[j][i] <= DRW'(t[i] - (DRW+1)'(lin));
            dv_q[j][i]   <= {qin[i][FB-1:0], 1'b1};
          end else begin
            dv_rem[j][i] <= DRW'(t[i]);
            dv_q[j][i]   <= {qin[i][FB-1:0], 1'b0};
          end
          dv_nl[j][i] <= {nlin[i][FB-1:0], 1'b0};
        end
      end
    end
  end

  // clamp to one, apply sign, zero vector gives zero
  logic [FB:0] qc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q[FB][i] > ONE) ? ONE : dv_q[FB][i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_l[LAT-1]) begin
          unit[i] <= '0;
        end else if (neg_l[LAT-1][i]) begin
          unit[i] <= -$signed({1'b0, qc[i]});
        end else begin
          unit[i] <= $signed({1'b0, qc[i]});
        end
      end
    end
  end

  assign vout     = vld[LAT];
  assign side_out = side_l[LAT];

endmodule

`default_nettype wire

@@ rtl/core/look_at_view_matrix.sv @@
// Left-handed look-at view matrix unit, fully pipelined.
// A request carries eye, target and up points (signed fixed point, FRAC_BITS
// fraction bits). The result carries the right, upward and forward axes and
// the three translation terms of the view matrix.
// Both channels use valid/stall; a request is taken when in_valid is high and
// in_stall is low, a result when out_valid is high and out_stall is low.
// Throughput: one request per cycle while no waiting result stalls the pipeline.
// Most of the pipeline depth lies in the two normalisers, each of which
// spends one stage per square-root bit and one per quotient bit.
// While the result register holds an untaken result and out_stall is high,
// every stage holds and in_stall is raised; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; the pipeline is empty after reset.
// A zero-length forward or right vector normalises to zero.
`default_nettype none

module look_at_view_matrix #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] eye_x,
  input  logic signed [DATA_WIDTH-1:0] eye_y,
  input  logic signed [DATA_WIDTH-1:0] eye_z,
  input  logic signed [DATA_WIDTH-1:0] target_x,
  input  logic signed [DATA_WIDTH-1:0] target_y,
  input  logic signed [DATA_WIDTH-1:0] target_z,
  input  logic signed [DATA_WIDTH-1:0] up_x,
  input  logic signed [DATA_WIDTH-1:0] up_y,
  input  logic signed [DATA_WIDTH-1:0] up_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [FRAC_BITS+1:0]  right_x,
  output logic signed [FRAC_BITS+1:0]  right_y,
  output logic signed [FRAC_BITS+1:0]  right_z,
  output logic signed [FRAC_BITS+1:0]  upward_x,
  output logic signed [FRAC_BITS+1:0]  upward_y,
  output logic signed [FRAC_BITS+1:0]  upward_z,
  output logic signed [FRAC_BITS+1:0]  forward_x,
  output logic signed [FRAC_BITS+1:0]  forward_y,
  output logic signed [FRAC_BITS+1:0]  forward_z,
  output logic signed [DATA_WIDTH-1:0] shift_x,
  output logic signed [DATA_WIDTH-1:0] shift_y,
  output logic signed [DATA_WIDTH-1:0] shift_z
);
  import lav_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int AW    = F + 2;
  localparam int UPM_W = (DW > UP_MAG_BITS) ? UP_MAG_BITS : DW;
  localparam int UPW   = UPM_W + 1;
  localparam int PW    = UPW + AW;
  localparam int CW    = PW + 1;
  localparam int UW2   = 2 * AW + 1;
  localparam int HW    = AW + DW - F + 2;
  localparam int LW    = AW + F + 3;
  localparam int RLW   = LW - F + 1;
  localparam int SW    = ((HW > RLW) ? HW : RLW) + 2;
  localparam int BLW   = $clog2(DW + 1);
  localparam logic [AW-1:0]  ONE    = AW'(1) << F;
  localparam logic [UW2-1:0] UHALF  = UW2'(1) << (F - 1);
  localparam logic [LW-1:0]  LHALF  = LW'(1) << (F - 1);
  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic en;
  logic v_s0, v_n1, v_x1, v_x2, v_x3, v_n2, v_u1, v_u2, v_d1, v_d2, v_d3, v_d4;

  // the whole pipeline holds while a finished result waits
  assign en       = !(v_d4 && out_stall);
  assign in_stall = v_d4 && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s0 <= 1'b0;
      v_x1 <= 1'b0;
      v_x2 <= 1'b0;
      v_x3 <= 1'b0;
      v_u1 <= 1'b0;
      v_u2 <= 1'b0;
      v_d1 <= 1'b0;
      v_d2 <= 1'b0;
      v_d3 <= 1'b0;
      v_d4 <= 1'b0;
    end else if (en) begin
      v_s0 <= in_valid;
      v_x1 <= v_n1;
      v_x2 <= v_x1;
      v_x3 <= v_x2;
      v_u1 <= v_n2;
      v_u2 <= v_u1;
      v_d1 <= v_u2;
      v_d2 <= v_d1;
      v_d3 <= v_d2;
      v_d4 <= v_d3;
    end
  end

  // input register: view direction, eye and raw up
  logic signed [DW:0]   d0 [3];
  logic signed [DW-1:0] eye0 [3];
  logic signed [DW-1:0] up0 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      d0[0]   <= (DW+1)'(target_x) - (DW+1)'(eye_x);
      d0[1]   <= (DW+1)'(target_y) - (DW+1)'(eye_y);
      d0[2]   <= (DW+1)'(target_z) - (DW+1)'(eye_z);
      eye0[0] <= eye_x;
      eye0[1] <= eye_y;
      eye0[2] <= eye_z;
      up0[0]  <= up_x;
      up0[1]  <= up_y;
      up0[2]  <= up_z;
    end
  end

  // forward axis
  logic [6*DW-1:0]      side1_in, side1_out;
  logic signed [AW-1:0] fw_n1 [3];
  assign side1_in = {eye0[2], eye0[1], eye0[0], up0[2], up0[1], up0[0]};

  lav_norm #(.VW(DW + 1), .FB(F), .SIDE_W(6 * DW)) u_norm_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v_s0),
    .vec      (d0),
    .side_in  (side1_in),
    .vout     (v_n1),
    .unit     (fw_n1),
    .side_out (side1_out)
  );

  logic signed [DW-1:0] eye_n1 [3];
  logic signed [DW-1:0] up_n1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_n1[i]  = side1_out[i*DW +: DW];
      eye_n1[i] = side1_out[(3+i)*DW +: DW];
    end
  end

  // bring wide up vectors below the cross-product width
  logic [DW-1:0]    umag [3];
  logic [DW-1:0]    uor;
  logic [BLW-1:0]   ublen;
  logic [BLW-1:0]   ush;
  logic [DW-1:0]    usc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      umag[i] = up_n1[i][DW-1] ? DW'(-up_n1[i]) : DW'(up_n1[i]);
    end
    uor   = umag[0] | umag[1] | umag[2];
    ublen = '0;
    for (int j = 0; j < DW; j++) begin
      if (uor[j]) ublen = BLW'(j + 1);
    end
    ush = (ublen > BLW'(UP_MAG_BITS)) ? ublen - BLW'(UP_MAG_BITS) : '0;
    for (int i = 0; i < 3; i++) usc[i] = umag[i] >> ush;
  end

  logic signed [UPW-1:0] up1 [3];
  logic signed [AW-1:0]  fw1 [3];
  logic signed [DW-1:0]  eye1 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        up1[i]  <= up_n1[i][DW-1] ? -$signed({1'b0, usc[i][UPM_W-1:0]})
                                  :  $signed({1'b0, usc[i][UPM_W-1:0]});
        fw1[i]  <= fw_n1[i];
        eye1[i] <= eye_n1[i];
      end
    end
  end

  // cross product of up and forward: partial products then differences
  logic signed [PW-1:0] pc2 [6];
  logic signed [AW-1:0] fw2 [3];
  logic signed [DW-1:0] eye2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      pc2[0] <= up1[1] * fw1[2];
      pc2[1] <= up1[2] * fw1[1];
      pc2[2] <= up1[2] * fw1[0];
      pc2[3] <= up1[0] * fw1[2];
      pc2[4] <= up1[0] * fw1[1];
      pc2[5] <= up1[1] * fw1[0];
      for (int i = 0; i < 3; i++) begin
        fw2[i]  <= fw1[i];
        eye2[i] <= eye1[i];
      end
    end
  end

  logic signed [CW-1:0] c3 [3];
  logic signed [AW-1:0] fw3 [3];
  logic signed [DW-1:0] eye3 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c3[i]   <= CW'(pc2[2*i]) - CW'(pc2[2*i+1]);
        fw3[i]  <= fw2[i];
        eye3[i] <= eye2[i];
      end
    end
  end

  // right axis
  logic [3*DW+3*AW-1:0] side2_in, side2_out;
  logic signed [AW-1:0] rt_n2 [3];
  assign side2_in = {eye3[2], eye3[1], eye3[0], fw3[2], fw3[1], fw3[0]};

  lav_norm #(.VW(CW), .FB(F), .SIDE_W(3 * DW + 3 * AW)) u_norm_right (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (v_x3),
    .vec      (c3),
    .side_in  (side2_in),
    .vout     (v_n2),
    .unit     (rt_n2),
    .side_out (side2_out)
  );

  logic signed [AW-1:0] fw_n2 [3];
  logic signed [DW-1:0] eye_n2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fw_n2[i]  = side2_out[i*AW +: AW];
      eye_n2[i] = side2_out[3*AW + i*DW +: DW];
    end
  end

  // upward axis: forward cross right
  logic signed [2*AW-1:0] pu1 [6];
  logic signed [AW-1:0]   rt_u1 [3];
  logic signed [AW-1:0]   fw_u1 [3];
  logic signed [DW-1:0]   eye_u1 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      pu1[0] <= fw_n2[1] * rt_n2[2];
      pu1[1] <= fw_n2[2] * rt_n2[1];
      pu1[2] <= fw_n2[2] * rt_n2[0];
      pu1[3] <= fw_n2[0] * rt_n2[2];
      pu1[4] <= fw_n2[0] * rt_n2[1];
      pu1[5] <= fw_n2[1] * rt_n2[0];
      for (int i = 0; i < 3; i++) begin
        rt_u1[i]  <= rt_n2[i];
        fw_u1[i]  <= fw_n2[i];
        eye_u1[i] <= eye_n2[i];
      end
    end
  end

  // round to nearest, halves away from zero, then clamp to one
  logic signed [UW2-1:0] udiff [3];
  logic [UW2-1:0]        umg [3];
  logic [UW2-1:0]        urnd [3];
  logic [AW-1:0]         ucl [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      udiff[i] = UW2'(pu1[2*i]) - UW2'(pu1[2*i+1]);
      umg[i]   = udiff[i][UW2-1] ? UW2'(-udiff[i]) : UW2'(udiff[i]);
      urnd[i]  = (umg[i] + UHALF) >> F;
      ucl[i]   = (urnd[i] > UW2'(ONE)) ? ONE : urnd[i][AW-1:0];
    end
  end

  logic signed [AW-1:0] ax2 [3][3];
  logic signed [DW-1:0] eye_u2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ax2[0][i] <= rt_u1[i];
        ax2[1][i] <= udiff[i][UW2-1] ? -$signed(ucl[i]) : $signed(ucl[i]);
        ax2[2][i] <= fw_u1[i];
        eye_u2[i] <= eye_u1[i];
      end
    end
  end

  // translation: axis times integer and fraction parts of eye
  logic signed [DW-F-1:0]    eh [3];
  logic signed [F:0]         el [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eh[i] = eye_u2[i][DW-1:F];
      el[i] = $signed({1'b0, eye_u2[i][F-1:0]});
    end
  end

  logic signed [AW+DW-F-1:0] ph1 [3][3];
  logic signed [AW+F:0]      pl1 [3][3];
  logic signed [AW-1:0]      ax_d1 [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          ph1[a][i]   <= ax2[a][i] * eh[i];
          pl1[a][i]   <= ax2[a][i] * el[i];
          ax_d1[a][i] <= ax2[a][i];
        end
      end
    end
  end

  logic signed [HW-1:0] hi2 [3];
  logic signed [LW-1:0] lo2 [3];
  logic signed [AW-1:0] ax_d2 [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        hi2[a] <= HW'(ph1[a][0]) + HW'(ph1[a][1]) + HW'(ph1[a][2]);
        lo2[a] <= LW'(pl1[a][0]) + LW'(pl1[a][1]) + LW'(pl1[a][2]);
        for (int i = 0; i < 3; i++) ax_d2[a][i] <= ax_d1[a][i];
      end
    end
  end

  // round the fraction sum back to the eye scale
  logic [LW-1:0] lmg [3];
  logic [LW-1:0] lrnd [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lmg[a]  = lo2[a][LW-1] ? LW'(-lo2[a]) : LW'(lo2[a]);
      lrnd[a] = (lmg[a] + LHALF) >> F;
    end
  end

  logic signed [HW-1:0]  hi3 [3];
  logic signed [RLW-1:0] rl3 [3];
  logic signed [AW-1:0]  ax_d3 [3][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        hi3[a] <= hi2[a];
        rl3[a] <= lo2[a][LW-1] ? -$signed({1'b0, lrnd[a][RLW-2:0]})
                               :  $signed({1'b0, lrnd[a][RLW-2:0]});
        for (int i = 0; i < 3; i++) ax_d3[a][i] <= ax_d2[a][i];
      end
    end
  end

  // negate and saturate
  logic signed [SW-1:0] rs [3];
  logic signed [DW-1:0] rsat [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rs[a] = -(SW'(hi3[a]) + SW'(rl3[a]));
      if (rs[a] > SMAX) begin
        rsat[a] = SMAX[DW-1:0];
      end else if (rs[a] < SMIN) begin
        rsat[a] = SMIN[DW-1:0];
      end else begin
        rsat[a] = rs[a][DW-1:0];
      end
    end
  end

  // result register
  logic signed [AW-1:0] ax4 [3][3];
  logic signed [DW-1:0] sh4 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sh4[a] <= rsat[a];
        for (int i = 0; i < 3; i++) ax4[a][i] <= ax_d3[a][i];
      end
    end
  end

  assign out_valid = v_d4;
  assign right_x   = ax4[0][0];
  assign right_y   = ax4[0][1];
  assign right_z   = ax4[0][2];
  assign upward_x  = ax4[1][0];
  assign upward_y  = ax4[1][1];
  assign upward_z  = ax4[1][2];
  assign forward_x = ax4[2][0];
  assign forward_y = ax4[2][1];
  assign forward_z = ax4[2][2];
  assign shift_x   = sh4[0];
  assign shift_y   = sh4[1];
  assign shift_z   = sh4[2];

endmodule

`default_nettype wire

@@ test/look_at_view_matrix_tb.sv @@
// testbench for the look-at view matrix unit: fixed-point model, random and directed requests
`default_nettype none

module look_at_view_matrix_tb;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int AW = FB + 2;
  localparam int LATENCY = 2 * FB + 88;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [AW-1:0] rt [3];
    logic signed [AW-1:0] uw [3];
    logic signed [AW-1:0] fw [3];
    logic signed [DW-1:0] sh [3];
  } view_basis_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [DW-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [DW-1:0] up_x = '0, up_y = '0, up_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AW-1:0] right_x, right_y, right_z;
  logic signed [AW-1:0] upward_x, upward_y, upward_z;
  logic signed [AW-1:0] forward_x, forward_y, forward_z;
  logic signed [DW-1:0] shift_x, shift_y, shift_z;

  view_basis_t pending_views [$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  longint cycle_count = 0;

  look_at_view_matrix #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
    .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
    .shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned abs_val(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint round_frac(longint x);
    longint unsigned m;
    m = (abs_val(x) + (64'd1 << (FB - 1))) >> FB;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // block-scaled unit vector, zero for zero length
  function automatic void unit_vec(input longint v [3], output longint u [3]);
    longint unsigned m [3];
    longint unsigned top, sum, len, q;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs_val(v[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (len >> 1)) / len;
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint eye_translation(longint a [3], longint e [3]);
    longint hi, lo, el, eh, r;
    longint top;
    hi = 0;
    lo = 0;
    top = longint'(1) <<< (DW - 1);
    for (int i = 0; i < 3; i++) begin
      el = e[i] & ((longint'(1) <<< FB) - 1);
      eh = (e[i] - el) >>> FB;
      hi += a[i] * eh;
      lo += a[i] * el;
    end
    r = -(hi + round_frac(lo));
    if (r > top - 1) r = top - 1;
    if (r < -top) r = -top;
    return r;
  endfunction

  function automatic longint clamp_one(longint x);
    longint one;
    one = longint'(1) <<< FB;
    if (x > one) return one;
    if (x < -one) return -one;
    return x;
  endfunction

  function automatic view_basis_t predict_view(input logic signed [DW-1:0] pt [9]);
    view_basis_t res;
    longint eye [3], d [3], up [3], fw [3], c [3], rt [3], uw [3];
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'(pt[i]);
      d[i] = longint'(pt[3 + i]) - eye[i];
      up[i] = longint'(pt[6 + i]);
    end
    unit_vec(d, fw);
    c[0] = up[1] * fw[2] - up[2] * fw[1];
    c[1] = up[2] * fw[0] - up[0] * fw[2];
    c[2] = up[0] * fw[1] - up[1] * fw[0];
    unit_vec(c, rt);
    uw[0] = clamp_one(round_frac(fw[1] * rt[2] - fw[2] * rt[1]));
    uw[1] = clamp_one(round_frac(fw[2] * rt[0] - fw[0] * rt[2]));
    uw[2] = clamp_one(round_frac(fw[0] * rt[1] - fw[1] * rt[0]));
    for (int i = 0; i < 3; i++) begin
      res.rt[i] = AW'(rt[i]);
      res.uw[i] = AW'(uw[i]);
      res.fw[i] = AW'(fw[i]);
    end
    res.sh[0] = DW'(eye_translation(rt, eye));
    res.sh[1] = DW'(eye_translation(uw, eye));
    res.sh[2] = DW'(eye_translation(fw, eye));
    return res;
  endfunction

  // ---------------- request driver ----------------
  task automatic send_request(input logic signed [DW-1:0] pt [9]);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    eye_x <= pt[0]; eye_y <= pt[1]; eye_z <= pt[2];
    target_x <= pt[3]; target_y <= pt[4]; target_z <= pt[5];
    up_x <= pt[6]; up_y <= pt[7]; up_z <= pt[8];
    do @(posedge clk); while (in_stall);
    pending_views.push_back(predict_view(pt));
  endtask

  // receiver stall
  always @(posedge clk) begin
    out_stall <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result", $time);
        errors = errors + 1;
      end else begin
        view_basis_t ex;
        logic signed [AW-1:0] got_a [9];
        logic signed [DW-1:0] got_s [3];
        ex = pending_views.pop_front();
        got_a = '{right_x, right_y, right_z, upward_x, upward_y, upward_z,
                  forward_x, forward_y, forward_z};
        got_s = '{shift_x, shift_y, shift_z};
        for (int i = 0; i < 3; i++) begin
          if (got_a[i] !== ex.rt[i] || got_a[3 + i] !== ex.uw[i] || got_a[6 + i] !== ex.fw[i]
              || got_s[i] !== ex.sh[i]) begin
            $display("%0t: axis %0d expected rt %0d uw %0d fw %0d sh %0d got %0d %0d %0d %0d",
                     $time, i, ex.rt[i], ex.uw[i], ex.fw[i], ex.sh[i],
                     got_a[i], got_a[3 + i], got_a[6 + i], got_s[i]);
            errors = errors + 1;
          end
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------- tests ----------------
  function automatic logic signed [DW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(2000)) - 1000;
      2: return ($urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000) ^ $urandom_range(3);
      default: return $signed({{12{1'b0}}, 20'($urandom)}) - 32'sd524288;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [DW-1:0] p [9];
    logic signed [DW-1:0] mx, mn, one;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    one = 32'sd65536;
    // ordinary camera looking along +z
    p = '{0, 0, 0, 0, 0, one, 0, one, 0}; send_request(p);
    // target equals eye
    p = '{one, 2 * one, 3, one, 2 * one, 3, 0, one, 0}; send_request(p);
    // zero up
    p = '{0, 0, 0, one, one, 0, 0, 0, 0}; send_request(p);
    // up parallel to forward
    p = '{5, 5, 5, 5, 5, one + 5, 0, 0, 3 * one}; send_request(p);
    // field extremes
    p = '{mn, mn, mn, mx, mx, mx, mx, mn, mx}; send_request(p);
    p = '{mx, mx, mx, mn, mn, mn, mn, mx, mn}; send_request(p);
    p = '{mx, mn, mx, mx, mx, mx, mn, mn, mn}; send_request(p);
    p = '{mx, mx, mx, 0, 0, 0, mx, mx, mx}; send_request(p);
    p = '{-1, -1, -1, 1, 1, 1, -1, 1, 0}; send_request(p);
    p = '{mn, 0, mx, 0, mx, 0, 1, -1, 1}; send_request(p);
    p = '{32'sh0000_8000, -32'sh0000_8000, 32'sh0001_8000, 0, 0, 0, 0, 1, 0};
    send_request(p);
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    logic signed [DW-1:0] p [9];
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) begin
      for (int i = 0; i < 9; i++) p[i] = rand_coord();
      // occasional degenerate requests
      if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) p[3 + i] = p[i];
      if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) p[6 + i] = 0;
      send_request(p);
    end
  endtask

  task automatic test_back_pressure();
    logic signed [DW-1:0] p [9];
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (160) begin
        for (int i = 0; i < 9; i++) p[i] = rand_coord();
        send_request(p);
      end
    join
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100, 0, 0);
    test_random(80, 84, 0);
    test_random(80, 0, 84);
    test_random(80, 10, 10);
    test_back_pressure();
    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && pending_views.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
